### design/flt_pkg.sv
// types and constants shared by the linear tween block
// payload structs for the input and result channels; no dependencies
package flt_pkg;

    localparam int ACC_W = 32;   // accumulator and increment width
    localparam int POS_W = 16;   // integer position width
    localparam int CNT_W = 15;   // tick count width

    typedef struct packed {
        logic                    cmd;
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic        [CNT_W-1:0] step_count;
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
    } tween_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    done_res;
    } tween_out_t;

    localparam logic CMD_CONTINUE = 1'b0;
    localparam logic CMD_START    = 1'b1;

endpackage

### design/fixed_point_linear_tween_unit.sv
// Flow: a continue item goes from acceptance through ST_STEP, which waits for the output
// register to be free, into the output register. A start item with a nonzero step count
// passes through ST_DIV first: a bit-serial restoring divider produces one quotient bit a
// cycle for both axes side by side. A start with a zero count skips ST_DIV and snaps at
// once. A new item is accepted while an earlier result still waits in the output
// register. No memories, so there is no clearing pass after reset.
// linear tween top level: fixed-point position stepping toward a target
// depends on flt_pkg
module fixed_point_linear_tween_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  flt_pkg::tween_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output flt_pkg::tween_out_t m_data
);

    localparam int ACC_W  = flt_pkg::ACC_W;
    localparam int POS_W  = flt_pkg::POS_W;
    localparam int CNT_W  = flt_pkg::CNT_W;
    localparam int DVD_W  = POS_W + FRAC_BITS;   // dividend magnitude bits
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP
    } state_t;

    state_t state_reg;

    logic [ACC_W-1:0] accum_x_reg, accum_y_reg;
    logic [ACC_W-1:0] inc_x_reg, inc_y_reg;
    logic [CNT_W-1:0] ticks_reg;
    logic [POS_W-1:0] goal_x_reg, goal_y_reg;

    // divider lanes: 0 is x, 1 is y
    logic [CNT_W-1:0]  divisor_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0]  rem_reg  [2];
    logic [DVD_W-1:0]  dvd_reg  [2];
    logic              neg_reg  [2];
    logic [CNT_W-1:0]  rem_next [2];
    logic [DVD_W-1:0]  dvd_next [2];
    logic [ACC_W-1:0]  quo      [2];

    logic              m_valid_reg;
    flt_pkg::tween_out_t m_data_reg;

    // start-time operands
    logic [POS_W:0]   diff_x, diff_y, mag_x, mag_y;
    logic [ACC_W-1:0] load_x, load_y;

    // tick step
    logic [ACC_W-1:0] sum_x, sum_y;
    logic [CNT_W-1:0] ticks_dec;
    logic             step_done;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        diff_x = {s_data.goal_x[POS_W-1], s_data.goal_x}
               - {s_data.origin_x[POS_W-1], s_data.origin_x};
        diff_y = {s_data.goal_y[POS_W-1], s_data.goal_y}
               - {s_data.origin_y[POS_W-1], s_data.origin_y};
        mag_x  = diff_x[POS_W] ? -diff_x : diff_x;
        mag_y  = diff_y[POS_W] ? -diff_y : diff_y;
        load_x = (ACC_W'(signed'(s_data.origin_x)) << FRAC_BITS) | HALF;
        load_y = (ACC_W'(signed'(s_data.origin_y)) << FRAC_BITS) | HALF;
    end

    // one restoring-division bit per lane per cycle
    always_comb begin
        logic [CNT_W:0] trial;
        logic [CNT_W:0] sub;
        logic           ge;
        for (int l = 0; l < 2; l++) begin
            trial       = {rem_reg[l], dvd_reg[l][DVD_W-1]};
            sub         = trial - {1'b0, divisor_reg};
            ge          = (trial >= {1'b0, divisor_reg});
            rem_next[l] = ge ? sub[CNT_W-1:0] : trial[CNT_W-1:0];
            dvd_next[l] = {dvd_reg[l][DVD_W-2:0], ge};
            quo[l]      = neg_reg[l] ? -ACC_W'(dvd_next[l]) : ACC_W'(dvd_next[l]);
        end
    end

    always_comb begin
        sum_x     = accum_x_reg + inc_x_reg;
        sum_y     = accum_y_reg + inc_y_reg;
        ticks_dec = (ticks_reg != '0) ? ticks_reg - CNT_W'(1) : '0;
        step_done = (ticks_dec == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            accum_x_reg <= '0;
            accum_y_reg <= '0;
            inc_x_reg   <= '0;
            inc_y_reg   <= '0;
            ticks_reg   <= '0;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            div_cnt_reg <= '0;
        end else begin
            // a tick step refills the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_STEP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.cmd == flt_pkg::CMD_START) begin
                            goal_x_reg  <= s_data.goal_x;
                            goal_y_reg  <= s_data.goal_y;
                            ticks_reg   <= s_data.step_count;
                            accum_x_reg <= load_x;
                            accum_y_reg <= load_y;
                            divisor_reg <= s_data.step_count;
                            div_cnt_reg <= '0;
                            rem_reg[0]  <= '0;
                            rem_reg[1]  <= '0;
                            dvd_reg[0]  <= {mag_x[POS_W-1:0], FRAC_BITS'(0)};
                            dvd_reg[1]  <= {mag_y[POS_W-1:0], FRAC_BITS'(0)};
                            neg_reg[0]  <= diff_x[POS_W];
                            neg_reg[1]  <= diff_y[POS_W];
                            if (s_data.step_count == '0) begin
                                // zero count: no division, snap on this tick
                                inc_x_reg <= '0;
                                inc_y_reg <= '0;
                                state_reg <= ST_STEP;
                            end else begin
                                state_reg <= ST_DIV;
                            end
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_DIV: begin
                    for (int l = 0; l < 2; l++) begin
                        rem_reg[l] <= rem_next[l];
                        dvd_reg[l] <= dvd_next[l];
                    end
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(DVD_W - 1)) begin
                        inc_x_reg <= quo[0];
                        inc_y_reg <= quo[1];
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (out_free) begin
                        accum_x_reg <= sum_x;
                        accum_y_reg <= sum_y;
                        ticks_reg   <= ticks_dec;
                        m_valid_reg <= 1'b1;
                        m_data_reg.pos_x <= step_done ? goal_x_reg
                                                      : sum_x[FRAC_BITS +: POS_W];
                        m_data_reg.pos_y <= step_done ? goal_y_reg
                                                      : sum_y[FRAC_BITS +: POS_W];
                        m_data_reg.done_res <= step_done;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

    a_div_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_cnt_reg < DCNT_W'(DVD_W))
        else $error("divider ran past its last bit");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted item left no work");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_STEP)
        else $error("result appeared outside a tick step");
`endif

endmodule

### test/tween_checker.sv
// result checker for the linear tween block: predicts each tick and compares results
// depends on flt_pkg; instantiated by testbench next to the block
module tween_checker
    import flt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  tween_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  tween_out_t m_data,
    output int         fail_count,
    output int         pending
);

    // predicted tween state
    logic [ACC_W-1:0] step_x, step_y;
    logic [ACC_W-1:0] acc_x, acc_y;
    logic [15:0]      ticks;
    logic [POS_W-1:0] goal_hold_x, goal_hold_y;

    tween_out_t expected_pos_q[$];
    tween_out_t want;
    int         mismatches = 0;

    // per-tick increment in fixed point, truncated toward zero, wrapped to 32 bits
    function automatic logic [ACC_W-1:0] slope_of(input logic signed [POS_W-1:0] goal,
                                                  input logic signed [POS_W-1:0] origin,
                                                  input logic [CNT_W-1:0] n);
        longint scaled;
        longint quot;
        if (n == '0) return '0;
        scaled = (longint'(goal) - longint'(origin)) <<< FRAC_BITS;
        quot   = scaled / longint'(n);
        return quot[ACC_W-1:0];
    endfunction

    // origin plus one half
    function automatic logic [ACC_W-1:0] seed_accum(input logic signed [POS_W-1:0] origin);
        return (32'(origin) << FRAC_BITS) | (32'd1 << (FRAC_BITS - 1));
    endfunction

    function automatic tween_out_t advance_tween(input tween_in_t t);
        tween_out_t r;
        if (t.cmd == CMD_START) begin
            goal_hold_x = t.goal_x;
            goal_hold_y = t.goal_y;
            ticks       = 16'(t.step_count);
            step_x      = slope_of(t.goal_x, t.origin_x, t.step_count);
            step_y      = slope_of(t.goal_y, t.origin_y, t.step_count);
            acc_x       = seed_accum(t.origin_x);
            acc_y       = seed_accum(t.origin_y);
        end
        acc_x   = acc_x + step_x;
        acc_y   = acc_y + step_y;
        r.pos_x = 16'($signed(acc_x) >>> FRAC_BITS);
        r.pos_y = 16'($signed(acc_y) >>> FRAC_BITS);
        // count saturates at zero, after which the position stays snapped
        if (ticks != 16'd0) ticks = ticks - 16'd1;
        r.done_res = (ticks == 16'd0);
        if (r.done_res) begin
            r.pos_x = goal_hold_x;
            r.pos_y = goal_hold_y;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int wanted);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] tween %s: got %0d, expected %0d", $time, field, got, wanted);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            step_x      = '0;
            step_y      = '0;
            acc_x       = '0;
            acc_y       = '0;
            ticks       = '0;
            goal_hold_x = '0;
            goal_hold_y = '0;
            expected_pos_q.delete();
            fail_count <= mismatches;
            pending    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pos_q.size() == 0) begin
                    report_mismatch("result with no item waiting, pos_x", int'(m_data.pos_x), 0);
                end else begin
                    want = expected_pos_q.pop_front();
                    if (m_data.pos_x !== want.pos_x)
                        report_mismatch("pos_x", int'(m_data.pos_x), int'(want.pos_x));
                    if (m_data.pos_y !== want.pos_y)
                        report_mismatch("pos_y", int'(m_data.pos_y), int'(want.pos_y));
                    if (m_data.done_res !== want.done_res)
                        report_mismatch("done_res", int'(m_data.done_res), int'(want.done_res));
                end
            end
            if (s_valid && s_ready)
                expected_pos_q.push_back(advance_tween(s_data));
            // counts reflect this edge's pushes and pops
            fail_count <= mismatches;
            pending    <= expected_pos_q.size();
        end
    end

endmodule

### test/testbench.sv
// top of the linear tween test: clock, reset, item stimulus and the verdict
// depends on flt_pkg, fixed_point_linear_tween_unit and tween_checker
module testbench;
    import flt_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int ITEM_TARGET = 1900;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    tween_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tween_out_t m_data;
    int         fail_count;
    int         pending;

    int sent       = 0;
    int burst_left = 1;

    fixed_point_linear_tween_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tween_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic tween_in_t make_item(input logic cmd,
                                            input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                                            input logic [CNT_W-1:0] n,
                                            input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy);
        tween_in_t t;
        t.cmd        = cmd;
        t.goal_x     = gx;
        t.goal_y     = gy;
        t.step_count = n;
        t.origin_x   = ox;
        t.origin_y   = oy;
        return t;
    endfunction

    // continue ticks carry random payload that the block must ignore
    function automatic tween_in_t continue_item();
        return make_item(CMD_CONTINUE, 16'($urandom), 16'($urandom), 15'($urandom),
                         16'($urandom), 16'($urandom));
    endfunction

    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short tweens so the done transition shows up often
    function automatic int pick_span();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 32767;
            2:       return $urandom_range(0, 32767);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // sender idles between bursts, a long burst now and then
    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // called at a falling edge, returns at a falling edge after acceptance
    task automatic offer(input tween_in_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
        pace();
    endtask

    initial begin
        int span;
        int extra;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // continue straight after reset acts as a finished tween at the origin
        offer(continue_item());
        // widest span in one tick, then a zero count that snaps at once
        offer(make_item(CMD_START, 16'h7FFF, 16'h8000, 15'd1, 16'h8000, 16'h7FFF));
        offer(make_item(CMD_START, 16'h7FFF, 16'h8000, 15'd0, 16'h8000, 16'h7FFF));
        // short tween run past its end
        offer(make_item(CMD_START, 16'h7FFF, 16'h8000, 15'd3, 16'h8000, 16'h7FFF));
        repeat (4) offer(continue_item());
        // longest count with the widest span the other way
        offer(make_item(CMD_START, 16'h8000, 16'h7FFF, 15'h7FFF, 16'h7FFF, 16'h8000));
        repeat (2) offer(continue_item());
        // fractional increments of both signs truncate toward zero
        offer(make_item(CMD_START, 16'd5, 16'hFFFB, 15'd7, 16'd0, 16'd0));
        repeat (8) offer(continue_item());
        // goal equal to origin
        offer(make_item(CMD_START, 16'd100, 16'hFF9C, 15'd2, 16'd100, 16'hFF9C));

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) != 0) begin
                span = pick_span();
                offer(make_item(CMD_START, pick_coord(), pick_coord(), 15'(span),
                                pick_coord(), pick_coord()));
                if (span <= 12)
                    extra = $urandom_range((span == 0) ? 0 : span - 1, span + 2);
                else
                    extra = $urandom_range(0, 6);
                repeat (extra) offer(continue_item());
            end else if ($urandom_range(0, 1) != 0) begin
                offer(make_item(CMD_START, 16'($urandom), 16'($urandom), 15'($urandom),
                                16'($urandom), 16'($urandom)));
            end else begin
                offer(continue_item());
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver: changing stall patterns plus long hold-offs that back up the block
    initial begin
        int cyc;
        int hold_left;
        int mode;
        int mode_left;
        cyc       = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc == 1500 || cyc == 15000) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_OPEN, RX_SPARSE);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 1) != 0);
                    default:   m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
